[sv/q4kr_pkg.sv]
// Shared types, constants and float helpers for the Q4_K block repacker.
// No dependencies; used by q4kr_scale_unit and q4k_block_repack.
`default_nettype none
package q4kr_pkg;

   localparam logic [7:0]  BLOCK_LAST   = 8'd143;
   localparam logic [7:0]  HEADER_BYTES = 8'd16;
   localparam logic [31:0] CANON_NAN    = 32'h7FC0_0000;
   localparam logic [30:0] EXP_ALL_ONES = 31'h7F80_0000;

   // word slots inside one emitted group of twelve
   localparam logic [3:0] SLOT_SCALE_A = 4'd0;
   localparam logic [3:0] SLOT_MIN_A   = 4'd1;
   localparam logic [3:0] SLOT_SCALE_B = 4'd6;
   localparam logic [3:0] SLOT_MIN_B   = 4'd7;
   localparam logic [3:0] SLOT_LAST    = 4'd11;

   typedef struct packed {
      logic [31:0] scale_a;
      logic [31:0] min_a;
      logic [31:0] scale_b;
      logic [31:0] min_b;
   } rec_scale_type;

   typedef struct packed {
      logic [5:0] scale_a;
      logic [5:0] min_a;
      logic [5:0] scale_b;
      logic [5:0] min_b;
   } sub_pair_type;

   // exact f16 -> f32, NaN folds to the canonical quiet NaN
   function automatic logic [31:0] half_to_single(input logic [15:0] h);
      logic [4:0]  ex;
      logic [9:0]  fr;
      logic [3:0]  p;
      logic [31:0] res;
      logic [31:0] sh;
      ex = h[14:10];
      fr = h[9:0];
      p  = 4'd0;
      for (int i = 0; i < 10; i++) begin
         if (fr[i]) p = 4'(i);
      end
      sh = {22'd0, fr} << (5'd23 - {1'b0, p});
      if (ex == 5'd31) begin
         res = (fr != 10'd0) ? CANON_NAN : {h[15], EXP_ALL_ONES};
      end else if (ex == 5'd0) begin
         if (fr == 10'd0) res = {h[15], 31'd0};
         else res = {h[15], 8'({4'd0, p} + 8'd103), sh[22:0]};
      end else begin
         res = {h[15], 8'({3'd0, ex} + 8'd112), fr, 13'd0};
      end
      return res;
   endfunction

   // exact f32 (from f16) times a 6-bit integer
   function automatic logic [31:0] mul_small(input logic [31:0] a, input logic [5:0] k);
      logic [29:0] prod;
      logic [2:0]  t;
      logic [29:0] norm;
      logic [31:0] res;
      prod = {1'b1, a[22:0]} * {18'd0, k};
      t = 3'd0;
      for (int i = 0; i < 7; i++) begin
         if (prod[23 + i]) t = 3'(i);
      end
      norm = prod >> t;
      if (a[30:0] > EXP_ALL_ONES) res = CANON_NAN;
      else if (a[30:23] == 8'hFF) res = (k == 6'd0) ? CANON_NAN : a;
      else if (a[30:0] == 31'd0 || k == 6'd0) res = {a[31], 31'd0};
      else res = {a[31], 8'(a[30:23] + {5'd0, t}), norm[22:0]};
      return res;
   endfunction

   // 6-bit scale and min of sub-block j from the twelve packed bytes
   function automatic logic [11:0] unpack_sub(input logic [95:0] s, input logic [2:0] j);
      logic [7:0] lo_b;
      logic [7:0] hi_b;
      logic [7:0] up_b;
      logic [11:0] res;
      lo_b = s[8 * j[1:0] +: 8];
      hi_b = s[8 * ({2'd0, j[1:0]} + 4'd4) +: 8];
      up_b = s[8 * ({2'd0, j[1:0]} + 4'd8) +: 8];
      if (!j[2]) res = {lo_b[5:0], hi_b[5:0]};
      else res = {lo_b[7:6], up_b[3:0], hi_b[7:6], up_b[7:4]};
      return res;
   endfunction

endpackage
`default_nettype wire

[sv/q4kr_code_ram.sv]
// Code word store: 8 entries of {high nibbles, low nibbles}, two banks of four.
// One write port, one read port with registered read data. No dependencies.
`default_nettype none
module q4kr_code_ram (
   input  wire logic        clock,
   input  wire logic        wr_en,
   input  wire logic [2:0]  wr_addr,
   input  wire logic [63:0] wr_data,
   input  wire logic [2:0]  rd_addr,
   output logic [63:0]      rd_data
);
   logic [63:0] mem [8];

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

[sv/q4kr_scale_unit.sv]
// Forms the four f32 words d*scale and dmin*min for the two records of a group.
// Depends on q4kr_pkg.
`default_nettype none
module q4kr_scale_unit (
   input  wire logic [31:0]             d_single,
   input  wire logic [31:0]             dmin_single,
   input  wire q4kr_pkg::sub_pair_type  subs,
   output q4kr_pkg::rec_scale_type      rec
);
   always_comb begin
      rec.scale_a = q4kr_pkg::mul_small(d_single, subs.scale_a);
      rec.min_a   = q4kr_pkg::mul_small(dmin_single, subs.min_a);
      rec.scale_b = q4kr_pkg::mul_small(d_single, subs.scale_b);
      rec.min_b   = q4kr_pkg::mul_small(dmin_single, subs.min_b);
   end
endmodule
`default_nettype wire

[sv/q4k_block_repack.sv]
// Q4_K super-block repacker.
// req_ channel: one stream byte per beat (req_data_byte, req_end_of_tensor).
// rsp_ channel: 32-bit words; each group of 32 code bytes yields twelve beats:
//   scale A, min A, four low-nibble words, scale B, min B, four high-nibble
//   words. rsp_run_last marks the twelfth, rsp_tensor_last the tensor's end.
// A group's first word is offered from the output register once its 32nd byte
// is taken; the rest follow one per cycle while rsp_stall stays low.
// Throughput: one byte per cycle unless req_stall is high. Groups are 32 bytes
// apart and each emits twelve words, so a closing byte is only held off while
// the previous group is still being emitted, i.e. under long output stalls.
// Code bytes land in a two-bank code RAM, one 64-bit write per 8 bytes; the
// emitter reads one entry per nibble word, its address taken from k_in.
// The f16 factors are converted to f32 in the header and multiplied by the
// 6-bit sub-scales when the group closes.
// Reset (synchronous) returns to the start of a block and drops any group in
// flight. While rsp_stall is high the output word holds; input bytes keep
// being taken until a further group would close.
// Depends on q4kr_pkg, q4kr_code_ram and q4kr_scale_unit.
`default_nettype none
module q4k_block_repack (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic        req_end_of_tensor,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [31:0]      rsp_out_word,
   output logic             rsp_run_last,
   output logic             rsp_tensor_last
);
   logic [7:0]  pos_ff, pos_in;
   logic [15:0] d_half_ff, dmin_half_ff;
   logic [95:0] subs_ff;
   logic [31:0] lo_acc_ff, hi_acc_ff;
   logic        wr_bank_ff;
   logic [31:0] d_single_ff, dmin_single_ff;
   q4kr_pkg::sub_pair_type  sub_pair_ff;
   q4kr_pkg::rec_scale_type rec_now;
   q4kr_pkg::rec_scale_type job_rec_ff;
   logic        job_active_ff, job_active_in;
   logic        job_bank_ff, job_bank_in;
   logic        job_eot_ff;
   logic [3:0]  k_ff, k_in;
   logic        rsp_valid_ff;
   logic [31:0] rsp_word_ff;
   logic        rsp_run_last_ff, rsp_tensor_last_ff;

   logic        in_fire, in_code, grp_end, load, start;
   logic [7:0]  off;
   logic [3:0]  sub_idx;
   logic [31:0] lo_w, hi_w;
   logic [63:0] rd_data;
   logic [3:0]  q_sub;
   logic [1:0]  rd_q;
   logic [31:0] word_sel;

   assign off     = pos_ff - q4kr_pkg::HEADER_BYTES;
   assign in_code = pos_ff >= q4kr_pkg::HEADER_BYTES;
   assign grp_end = in_code && (off[4:0] == 5'd31);
   assign req_stall = grp_end && job_active_ff;
   assign in_fire = req_valid && !req_stall;
   assign start   = in_fire && grp_end;
   assign sub_idx = 4'(pos_ff - 8'd4);

   always_comb begin
      lo_w = lo_acc_ff;
      hi_w = hi_acc_ff;
      lo_w[4 * off[2:0] +: 4] = req_data_byte[3:0];
      hi_w[4 * off[2:0] +: 4] = req_data_byte[7:4];
   end

   always_comb begin
      pos_in = pos_ff;
      if (in_fire) begin
         if (req_end_of_tensor || pos_ff == q4kr_pkg::BLOCK_LAST) pos_in = 8'd0;
         else pos_in = pos_ff + 8'd1;
      end
   end

   q4kr_scale_unit u_scale (
      .d_single    (d_single_ff),
      .dmin_single (dmin_single_ff),
      .subs        (sub_pair_ff),
      .rec         (rec_now)
   );

   // output stage and emission counter
   assign load = job_active_ff && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      job_active_in = job_active_ff;
      job_bank_in   = job_bank_ff;
      k_in          = k_ff;
      if (start) begin
         job_active_in = 1'b1;
         job_bank_in   = wr_bank_ff;
         k_in          = 4'd0;
      end else if (load) begin
         k_in = k_ff + 4'd1;
         if (k_ff == q4kr_pkg::SLOT_LAST) job_active_in = 1'b0;
      end
   end

   // read address always tracks the next counter value, so rd_data matches k_ff
   assign q_sub = (k_in < q4kr_pkg::SLOT_SCALE_B) ? k_in - 4'd2 : k_in - 4'd8;
   assign rd_q  = q_sub[1:0];

   q4kr_code_ram u_ram (
      .clock   (clock),
      .wr_en   (in_fire && in_code && off[2:0] == 3'd7),
      .wr_addr ({wr_bank_ff, off[4:3]}),
      .wr_data ({hi_w, lo_w}),
      .rd_addr ({job_bank_in, rd_q}),
      .rd_data (rd_data)
   );

   always_comb begin
      if (k_ff == q4kr_pkg::SLOT_SCALE_A) word_sel = job_rec_ff.scale_a;
      else if (k_ff == q4kr_pkg::SLOT_MIN_A) word_sel = job_rec_ff.min_a;
      else if (k_ff == q4kr_pkg::SLOT_SCALE_B) word_sel = job_rec_ff.scale_b;
      else if (k_ff == q4kr_pkg::SLOT_MIN_B) word_sel = job_rec_ff.min_b;
      else if (k_ff < q4kr_pkg::SLOT_SCALE_B) word_sel = rd_data[31:0];
      else word_sel = rd_data[63:32];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff        <= 8'd0;
         wr_bank_ff    <= 1'b0;
         job_active_ff <= 1'b0;
         job_bank_ff   <= 1'b0;
         k_ff          <= 4'd0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         pos_ff        <= pos_in;
         job_active_ff <= job_active_in;
         job_bank_ff   <= job_bank_in;
         k_ff          <= k_in;
         if (start) wr_bank_ff <= !wr_bank_ff;
         if (load) rsp_valid_ff <= 1'b1;
         else if (!rsp_stall) rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (in_fire) begin
         if (pos_ff == 8'd0) d_half_ff[7:0] <= req_data_byte;
         if (pos_ff == 8'd1) d_half_ff[15:8] <= req_data_byte;
         if (pos_ff == 8'd2) dmin_half_ff[7:0] <= req_data_byte;
         if (pos_ff == 8'd3) dmin_half_ff[15:8] <= req_data_byte;
         if (pos_ff >= 8'd4 && !in_code) subs_ff[8 * sub_idx +: 8] <= req_data_byte;
         if (in_code) begin
            lo_acc_ff <= lo_w;
            hi_acc_ff <= hi_w;
         end
      end
      d_single_ff    <= q4kr_pkg::half_to_single(d_half_ff);
      dmin_single_ff <= q4kr_pkg::half_to_single(dmin_half_ff);
      {sub_pair_ff.scale_a, sub_pair_ff.min_a} <= q4kr_pkg::unpack_sub(subs_ff, {off[6:5], 1'b0});
      {sub_pair_ff.scale_b, sub_pair_ff.min_b} <= q4kr_pkg::unpack_sub(subs_ff, {off[6:5], 1'b1});
      if (start) begin
         job_rec_ff <= rec_now;
         job_eot_ff <= req_end_of_tensor;
      end
      if (load) begin
         rsp_word_ff        <= word_sel;
         rsp_run_last_ff    <= k_ff == q4kr_pkg::SLOT_LAST;
         rsp_tensor_last_ff <= (k_ff == q4kr_pkg::SLOT_LAST) && job_eot_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_word    = rsp_word_ff;
   assign rsp_run_last    = rsp_run_last_ff;
   assign rsp_tensor_last = rsp_tensor_last_ff;

   a_stall_only_busy: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> job_active_ff)
      else $error("input held off with no group in emission");
   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= q4kr_pkg::BLOCK_LAST)
      else $error("byte position beyond block");
   a_slot_range: assert property (@(posedge clock) disable iff (reset)
      job_active_ff |-> k_ff <= q4kr_pkg::SLOT_LAST)
      else $error("emission counter beyond last slot");
   a_tensor_in_run: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_tensor_last_ff |-> rsp_run_last_ff)
      else $error("tensor end outside a group end");
endmodule
`default_nettype wire

[verif/tb_q4k_block_repack.sv]
// Self-checking testbench for q4k_block_repack: drives Q4_K super-block byte
// streams and checks every emitted word against a built-in predictor.
// Depends on q4kr_pkg (CANON_NAN) and the q4k_block_repack RTL.
`default_nettype none
module tb_q4k_block_repack;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [31:0] word;
      logic        run_last;
      logic        tensor_last;
   } rsp_beat_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_data_byte = 8'd0;
   logic        req_end_of_tensor = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [31:0] rsp_out_word;
   logic        rsp_run_last;
   logic        rsp_tensor_last;

   rsp_beat_type expected_words[$];
   int          mismatch_count = 0;

   // predictor state
   logic [7:0]  pr_pos = 8'd0;
   logic [15:0] pr_d, pr_dmin;
   logic [7:0]  pr_sub[12];
   logic [7:0]  pr_codes[32];

   // sender pacing and receiver hold-off
   int          burst_left = 0;
   int          hold_cycles = 0;
   bit          stall_enable = 1'b1;

   q4k_block_repack uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_data_byte(req_data_byte), .req_end_of_tensor(req_end_of_tensor),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_out_word(rsp_out_word), .rsp_run_last(rsp_run_last),
      .rsp_tensor_last(rsp_tensor_last)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   initial begin
      #5ms;
      $display("FAIL");
      $finish;
   end

   // f16 factor times a 6-bit integer, exact in f32
   function automatic logic [31:0] half_times(input logic [15:0] h, input logic [5:0] k);
      logic [4:0]  ex;
      logic [10:0] mant;
      int          e2;
      logic [17:0] p;
      int          msb;
      logic [40:0] shifted;
      ex = h[14:10];
      mant = (ex == 5'd0) ? {1'b0, h[9:0]} : {1'b1, h[9:0]};
      e2 = (ex == 5'd0) ? -24 : int'(ex) - 25;
      if (ex == 5'd31) begin
         if (h[9:0] != 10'd0 || k == 6'd0) return q4kr_pkg::CANON_NAN;
         return {h[15], 31'h7F80_0000};
      end
      if (mant == 11'd0 || k == 6'd0) return {h[15], 31'd0};
      p = mant * k;
      msb = 0;
      for (int i = 0; i < 18; i++) if (p[i]) msb = i;
      shifted = {23'd0, p} << (23 - msb);
      return {h[15], 8'(e2 + msb + 127), shifted[22:0]};
   endfunction

   // advance the predictor by one accepted byte, queueing any group output
   task automatic predict_byte(input logic [7:0] b, input logic eot);
      int          off, grp;
      logic [5:0]  sc[2], mn[2];
      logic [31:0] w[12];
      logic [7:0]  s[12];
      int          j;
      s = pr_sub;
      if (pr_pos < 2) pr_d[8*pr_pos +: 8] = b;
      else if (pr_pos < 4) pr_dmin[8*(pr_pos-2) +: 8] = b;
      else if (pr_pos < 16) pr_sub[pr_pos-4] = b;
      else begin
         off = pr_pos - 16;
         pr_codes[off % 32] = b;
         if (off % 32 == 31) begin
            grp = off / 32;
            for (int k = 0; k < 2; k++) begin
               j = 2*grp + k;
               if (j < 4) begin
                  sc[k] = s[j][5:0];
                  mn[k] = s[j+4][5:0];
               end else begin
                  sc[k] = {s[j-4][7:6], s[j+4][3:0]};
                  mn[k] = {s[j][7:6], s[j+4][7:4]};
               end
               w[6*k]   = half_times(pr_d, sc[k]);
               w[6*k+1] = half_times(pr_dmin, mn[k]);
            end
            for (int q = 0; q < 4; q++)
               for (int l = 0; l < 8; l++) begin
                  w[2+q][4*l +: 4] = pr_codes[8*q+l][3:0];
                  w[8+q][4*l +: 4] = pr_codes[8*q+l][7:4];
               end
            for (int k = 0; k < 12; k++)
               expected_words.push_back('{w[k], k == 11, k == 11 && eot});
         end
      end
      pr_pos = (eot || pr_pos == 8'd143) ? 8'd0 : pr_pos + 8'd1;
   endtask

   // send one beat: optional gap at the start of a burst, then hold until taken
   task automatic send_byte(input logic [7:0] b, input logic eot);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         req_valid = 1'b0;
         repeat ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6)) @(negedge clock);
      end
      burst_left--;
      req_valid = 1'b1;
      req_data_byte = b;
      req_end_of_tensor = eot;
      do @(posedge clock); while (req_stall);
      predict_byte(b, eot);
      @(negedge clock);
      // drop valid; the next beat of a burst raises it again at this same edge
      req_valid = 1'b0;
   endtask

   // one super-block; stop_at >= 0 ends the tensor on that byte
   task automatic send_block(input logic [15:0] d, input logic [15:0] dm, input int stop_at);
      logic [7:0] b;
      for (int i = 0; i < 144; i++) begin
         if (i == 0) b = d[7:0];
         else if (i == 1) b = d[15:8];
         else if (i == 2) b = dm[7:0];
         else if (i == 3) b = dm[15:8];
         else b = 8'($urandom);
         send_byte(b, i == stop_at);
         if (i == stop_at) return;
      end
   endtask

   function automatic logic [15:0] pick_half();
      case ($urandom_range(0, 9))
         0: return 16'h7C00;
         1: return 16'hFC00;
         2: return 16'h7E00 | 16'($urandom_range(0, 511));
         3: return 16'($urandom_range(0, 1023)) | ($urandom_range(0, 1) ? 16'h8000 : 16'h0);
         4: return $urandom_range(0, 1) ? 16'h0000 : 16'h8000;
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic wait_drained();
      while (expected_words.size() != 0) @(negedge clock);
      repeat (20) @(negedge clock);
   endtask

   task automatic test_directed_extremes();
      send_block(16'h8000, 16'h7C00, 47);   // negative zero, infinite min
      send_block(16'h7E01, 16'h0001, 47);   // NaN factor, smallest subnormal
      send_block(16'hFC00, 16'h03FF, 47);   // negative infinity, largest subnormal
      send_block(16'h7BFF, 16'hFBFF, 20);   // tensor ends inside a group: drop
      wait_drained();
   endtask

   task automatic test_random_stream();
      int sent;
      int stop;
      sent = 0;
      while (sent < 24) begin
         stop = $urandom_range(0, 1) ? 47 : $urandom_range(0, 46);
         send_block(pick_half(), pick_half(), stop);
         sent += stop + 1;
      end
      wait_drained();
   endtask

   // full block under a long receiver hold-off, so the input stalls
   task automatic test_output_backpressure();
      hold_cycles = 300;
      send_block(pick_half(), pick_half(), 143);
      wait_drained();
   endtask

   // receiver: random stall pattern, quiet stretches, and a long hold-off on request
   initial begin
      int phase;
      forever begin
         @(negedge clock);
         if (hold_cycles > 0) begin
            rsp_stall = 1'b1;
            hold_cycles--;
         end else begin
            phase = $urandom_range(0, 99);
            if (phase < 10) stall_enable = ~stall_enable;
            rsp_stall = stall_enable && ($urandom_range(0, 2) == 0);
         end
      end
   end

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch %s: got %h expected %h", what, got, want);
      mismatch_count++;
   endtask

   always @(posedge clock) begin
      rsp_beat_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_words.size() == 0) begin
            report_mismatch("unexpected beat", rsp_out_word, 32'd0);
         end else begin
            e = expected_words.pop_front();
            if (rsp_out_word !== e.word) report_mismatch("out_word", rsp_out_word, e.word);
            if (rsp_run_last !== e.run_last)
               report_mismatch("run_last", 32'(rsp_run_last), 32'(e.run_last));
            if (rsp_tensor_last !== e.tensor_last)
               report_mismatch("tensor_last", 32'(rsp_tensor_last), 32'(e.tensor_last));
         end
      end
   end

   initial begin
      repeat (5) @(negedge clock);
      reset = 1'b0;
      test_directed_extremes();
      test_random_stream();
      test_output_backpressure();
      if (mismatch_count == 0 && expected_words.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
`default_nettype wire
